// ===== design/box_blur_3x3_clipped_top_defines.svh =====
// assertion macros for the checker file of the box blur block
// no dependencies; included by bare file name
`ifndef BOX_BLUR_3X3_CLIPPED_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_CLIPPED_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BB3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bb3_pkg.sv =====
// shared types, constants and the reciprocal table of the box blur block
// no dependencies
`default_nettype none

package bb3_pkg;

	localparam int PIX_BITS          = 24;
	localparam int CH_BITS           = 8;
	localparam int NUM_CH            = 3;
	localparam int COLSUM_BITS       = 10;
	localparam int TOTAL_BITS        = 12;
	localparam int X_BITS            = 13;
	localparam int COUNT_BITS        = 4;
	localparam int RECIP_BITS        = 18;
	localparam int RECIP_SHIFT       = 18;

	localparam int FRAME_WIDTH_BITS  = 11;
	localparam int FRAME_HEIGHT_BITS = 13;
	localparam int CFG_DATA_BITS     = 13;
	localparam int CFG_INDEX_BITS    = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
	localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

	typedef logic [COLSUM_BITS-1:0] colsum_t;

	typedef struct packed {
		logic                  wr_en;
		logic [1:0]            wr_bank;
		logic                  rd_en;
		logic                  clear;
		logic                  shift;
		logic                  col_valid;
		logic                  use_up;
		logic                  use_down;
		logic [1:0]            row_bank;
		logic                  sum_en;
		logic [COUNT_BITS-1:0] n;
		logic                  div_en;
		logic                  load_out;
		logic                  frame_end;
	} cmd_t;

	// ceil(2^18 / (2n)) for the neighbour counts that can occur
	function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] n);
		logic [RECIP_BITS-1:0] m;
		case (n)
			4'd1:    m = 18'd131072;
			4'd2:    m = 18'd65536;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32768;
			4'd6:    m = 18'd21846;
			4'd9:    m = 18'd14564;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/bb3_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== design/bb3_datapath.sv =====
// line store banks, column-sum window, rounding divide and output register
// depends on bb3_pkg and bb3_ram
`default_nettype none

module bb3_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bb3_pkg::cmd_t                  cmd,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
	input  wire logic [bb3_pkg::PIX_BITS-1:0]   pix_in,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [bb3_pkg::PIX_BITS-1:0]   m_tdata,
	output logic                                m_tlast,
	output logic                                out_free
);

	import bb3_pkg::*;

	localparam int PRODW = X_BITS + RECIP_BITS;

	logic [PIX_BITS-1:0] bank_data [4];
	logic [PIX_BITS-1:0] px_up, px_mid, px_down;
	colsum_t             new_col [NUM_CH];
	colsum_t             win_q [3][NUM_CH];
	logic [TOTAL_BITS-1:0] total [NUM_CH];
	logic [X_BITS-1:0]   x_s1 [NUM_CH];
	logic [RECIP_BITS-1:0] recip_s1;
	logic [PRODW-1:0]    prod [NUM_CH];
	logic [CH_BITS-1:0]  q_s2 [NUM_CH];
	logic                valid_q;
	logic [PIX_BITS-1:0] data_q;
	logic                last_q;

	// one bank per row of the four-row ring
	for (genvar b = 0; b < 4; b++) begin : g_bank
		bb3_ram #(
			.WIDTH (PIX_BITS),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (cmd.wr_en && (cmd.wr_bank == 2'(b))),
			.wr_addr (wr_addr),
			.wr_data (pix_in),
			.rd_en   (cmd.rd_en),
			.rd_addr (rd_addr),
			.rd_data (bank_data[b])
		);
	end

	always_comb begin
		px_up   = bank_data[2'(cmd.row_bank - 2'd1)];
		px_mid  = bank_data[cmd.row_bank];
		px_down = bank_data[2'(cmd.row_bank + 2'd1)];
		for (int ch = 0; ch < NUM_CH; ch++) begin
			new_col[ch] = COLSUM_BITS'(px_mid[ch*CH_BITS +: CH_BITS]);
			if (cmd.use_up) begin
				new_col[ch] = new_col[ch] + COLSUM_BITS'(px_up[ch*CH_BITS +: CH_BITS]);
			end
			if (cmd.use_down) begin
				new_col[ch] = new_col[ch] + COLSUM_BITS'(px_down[ch*CH_BITS +: CH_BITS]);
			end
			if (!cmd.col_valid) begin
				new_col[ch] = '0;
			end
		end
	end

	// window holds column sums for the left, centre and right columns
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			for (int c = 0; c < 3; c++) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					win_q[c][ch] <= '0;
				end
			end
		end else if (cmd.shift) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				win_q[0][ch] <= win_q[1][ch];
				win_q[1][ch] <= win_q[2][ch];
				win_q[2][ch] <= new_col[ch];
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			total[ch] = TOTAL_BITS'(win_q[0][ch]) + TOTAL_BITS'(win_q[1][ch])
				+ TOTAL_BITS'(win_q[2][ch]);
			prod[ch] = PRODW'(x_s1[ch]) * PRODW'(recip_s1);
		end
	end

	// rounded quotient (2s + n) / (2n) by reciprocal multiply
	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				x_s1[ch] <= X_BITS'({total[ch], 1'b0}) + X_BITS'(cmd.n);
			end
			recip_s1 <= recip(cmd.n);
		end
		if (cmd.div_en) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				q_s2[ch] <= prod[ch][RECIP_SHIFT +: CH_BITS];
			end
		end
	end

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			data_q <= {q_s2[2], q_s2[1], q_s2[0]};
			last_q <= cmd.frame_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ===== design/bb3_ctrl.sv =====
// controller: frame registers, position counters and the result sequencer
// depends on bb3_pkg
`default_nettype none

module bb3_ctrl #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [bb3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [bb3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tuser,
	output logic                                     s_tready,
	input  wire logic                                out_free,
	output bb3_pkg::cmd_t                            cmd,
	output logic      [$clog2(MAX_WIDTH)-1:0]        wr_addr,
	output logic      [$clog2(MAX_WIDTH)-1:0]        rd_addr
);

	import bb3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD_A = 3'd1;
	localparam logic [2:0] ST_RD_B = 3'd2;
	localparam logic [2:0] ST_RD_C = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]                   state_q;
	logic [FRAME_WIDTH_BITS-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_BITS-1:0] frame_height_q;
	logic [AW-1:0]                in_col_q;
	logic [HW-1:0]                in_row_q;
	logic [AW-1:0]                out_col_q;
	logic [HW-1:0]                out_row_q;
	logic [PW-1:0]                pending_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [WW-1:0] in_col_next, out_col_next;
	logic [HW-1:0] out_row_next;
	logic          cfg_hit, accept, in_done, take_px, take_drain, emit_px;
	logic          row_start, left_ok, right_ok, up_ok, down_ok, w_gt1, done_out;
	logic [1:0]    nr, nc;

	// clamp the frame size into the supported range
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height_q);
		end
	end

	always_comb begin
		cfg_hit      = cfg_wr_en && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});
		s_tready     = (state_q == ST_IDLE);
		accept       = s_tvalid && s_tready;
		in_done      = (in_row_q >= h_eff);
		take_px      = accept && !s_tuser && !in_done;
		take_drain   = accept && s_tuser && in_done;
		emit_px      = (pending_q >= PW'(w_eff) + PW'(1));
		in_col_next  = WW'(in_col_q) + WW'(1);
		out_col_next = WW'(out_col_q) + WW'(1);
		out_row_next = out_row_q + HW'(1);
		row_start    = (out_col_q == '0);
		left_ok      = !row_start;
		right_ok     = (out_col_next < w_eff);
		up_ok        = (out_row_q != '0);
		down_ok      = (out_row_next < h_eff);
		w_gt1        = (w_eff > WW'(1));
		done_out     = (state_q == ST_OUT) && out_free;
		nr           = 2'd1 + 2'(up_ok) + 2'(down_ok);
		nc           = 2'd1 + 2'(left_ok) + 2'(right_ok);
	end

	always_comb begin
		cmd           = '0;
		cmd.wr_en     = take_px;
		cmd.wr_bank   = 2'(in_row_q);
		cmd.use_up    = up_ok;
		cmd.use_down  = down_ok;
		cmd.row_bank  = 2'(out_row_q);
		cmd.n         = COUNT_BITS'(nr) * COUNT_BITS'(nc);
		cmd.frame_end = (out_col_next == w_eff) && (out_row_next == h_eff);
		rd_addr       = '0;
		case (state_q)
			ST_RD_A: begin
				cmd.rd_en = 1'b1;
				cmd.clear = row_start;
				if (!row_start && right_ok) begin
					rd_addr = AW'(out_col_next);
				end
			end
			ST_RD_B: begin
				cmd.shift     = 1'b1;
				cmd.col_valid = row_start || right_ok;
				// row start needs the second column as well
				if (row_start) begin
					cmd.rd_en = 1'b1;
					if (w_gt1) begin
						rd_addr = AW'(1);
					end
				end
			end
			ST_RD_C: begin
				cmd.shift     = 1'b1;
				cmd.col_valid = w_gt1;
			end
			ST_SUM:  cmd.sum_en = 1'b1;
			ST_DIV:  cmd.div_en = 1'b1;
			ST_OUT:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	assign wr_addr = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if ((take_px && emit_px) || take_drain) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= row_start ? ST_RD_C : ST_SUM;
				ST_RD_C: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q <= cfg_data[FRAME_WIDTH_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// a register write or the last result restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (cfg_hit) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else begin
			if (take_px) begin
				if (in_col_next >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HW'(1);
				end else begin
					in_col_q <= AW'(in_col_next);
				end
				if (!emit_px) begin
					pending_q <= pending_q + PW'(1);
				end
			end
			if (take_drain) begin
				pending_q <= pending_q - PW'(1);
			end
			if (done_out) begin
				if (out_col_next >= w_eff) begin
					out_col_q <= '0;
					if (out_row_next >= h_eff) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_row_q <= '0;
						pending_q <= '0;
					end else begin
						out_row_q <= out_row_next;
					end
				end else begin
					out_col_q <= AW'(out_col_next);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/box_blur_3x3_clipped_top.sv =====
// 3x3 box blur with in-frame neighbour averaging, rgb stream in and out
// Input: s_tvalid/s_tready, s_tdata holds the rgb pixel, s_tuser marks a drain tick.
// Output: m_tvalid/m_tready, m_tdata holds the blurred pixel, m_tlast ends a frame.
// Config: cfg_wr_en writes frame_width (index 0) or frame_height (index 1) and
// restarts the frame; write only while the block is idle.
// A pixel that yields no result is taken without leaving the idle state. A pixel
// or drain tick that yields a result runs the sequencer: line store read, column-sum
// shift (a second read and shift at a row start), sum, reciprocal multiply and
// output load, which registers the result that then shows on m_tvalid.
// Results lag the pixel stream by one row plus one pixel; after the last pixel,
// width+1 drain ticks push out the remaining results (width on a one-row frame).
// Reset: frame size 640 x 480, all counters zero; the line banks are not cleared.
// Receiver stall: the finished result waits in the output register while pixels
// that yield no result are still taken; the next result holds in its final step.
// depends on bb3_pkg, bb3_ctrl, bb3_datapath
`default_nettype none

module box_blur_3x3_clipped_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [bb3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [bb3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [bb3_pkg::PIX_BITS-1:0]        s_tdata,  // red_in, green_in, blue_in
	input  wire logic                                s_tuser,  // kind
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [bb3_pkg::PIX_BITS-1:0]        m_tdata,  // red_out, green_out, blue_out
	output logic                                     m_tlast   // frame_end
);

	import bb3_pkg::*;

	cmd_t                         cmd;
	logic [$clog2(MAX_WIDTH)-1:0] wr_addr;
	logic [$clog2(MAX_WIDTH)-1:0] rd_addr;
	logic                         out_free;

	bb3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tuser   (s_tuser),
		.s_tready  (s_tready),
		.out_free  (out_free),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	bb3_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.pix_in   (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.out_free (out_free)
	);

endmodule

`default_nettype wire

// ===== design/bb3_checker.sv =====
// port-level checks of the box blur block, bound to the top level
// depends on bb3_pkg and box_blur_3x3_clipped_top_defines.svh
`default_nettype none

`include "box_blur_3x3_clipped_top_defines.svh"

module bb3_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [bb3_pkg::PIX_BITS-1:0]  m_tdata,
	input wire logic                          m_tlast
);

	// a stalled result stays offered
	`BB3_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// and keeps its payload
	`BB3_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// a new result is loaded only while input is held off
	`BB3_ASSERT_SAME(a_load_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready), "result appeared while input was open")

	// the result sequence keeps input closed beyond its first step
	`BB3_ASSERT_NEXT(a_busy_min, clk, arst_n, $fell(s_tready), !s_tready, "input reopened too early")

endmodule

bind box_blur_3x3_clipped_top bb3_checker u_bb3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
